/* hdl/lc4b5b_pkg.sv */
// ----------------------------------------------------------------------------
// lc4b5b_pkg
// Shared types, constants and the 4B5B symbol decoder for the 4B5B frame
// receiver and its checker.
// ----------------------------------------------------------------------------
package lc4b5b_pkg;

   // frame machine phases
   typedef enum logic [1:0] {
      PH_HUNT1   = 2'd0,
      PH_HUNT2   = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   // frame constants
   localparam logic [7:0] START_A    = 8'h18;
   localparam logic [7:0] START_B    = 8'h11;
   localparam logic [7:0] CHECK_SEED = 8'hFF;

   // payload length cap, clipped to what the 8-bit register can hold
   localparam int unsigned MAX_PAYLOAD = 255;
   localparam logic [7:0]  MAX_LEN_CAP = (MAX_PAYLOAD > 255) ? 8'hFF : 8'(MAX_PAYLOAD);

   // bit position of the last bit of a symbol pair
   localparam logic [3:0] LAST_BIT_POS = 4'd9;

   // csr register word index
   localparam logic REG_PAYLOAD_LENGTH = 1'b0;

   // one result item
   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] received_byte;
      logic       last_of_frame;
   } rsp_item_type;

   // 4B5B data symbol to nibble; codes outside the table give 0
   function automatic logic [3:0] decode_symbol(input logic [4:0] code);
      logic [3:0] nib;
      case (code)
         5'b01001: nib = 4'h1;
         5'b01010: nib = 4'h4;
         5'b01011: nib = 4'h5;
         5'b01110: nib = 4'h6;
         5'b01111: nib = 4'h7;
         5'b10010: nib = 4'h8;
         5'b10011: nib = 4'h9;
         5'b10100: nib = 4'h2;
         5'b10101: nib = 4'h3;
         5'b10110: nib = 4'hA;
         5'b10111: nib = 4'hB;
         5'b11010: nib = 4'hC;
         5'b11011: nib = 4'hD;
         5'b11100: nib = 4'hE;
         5'b11101: nib = 4'hF;
         5'b11110: nib = 4'h0;
         default:  nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

/* hdl/line_code_4b5b_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// line_code_4b5b_frame_receiver_unit
// Gathers sampled line bits into 4B5B symbol pairs, decodes bytes, hunts for
// the start pair 0x18 0x11 and delivers payload bytes and a checksum status.
// ----------------------------------------------------------------------------
// The block takes one line bit per cycle on the req channel while req_ready is
// high, with no gaps needed: the symbol shifter, the 4B5B table and the frame
// machine all act on each transfer. Every tenth bit completes a symbol pair and
// may yield one result (payload byte, or checksum status with last_of_frame
// set). Results wait in a two-entry buffer (output register plus skid
// register), so req_ready drops only when both entries are full; with rsp_ready
// held high the block sustains one bit per cycle. payload_length sits at byte
// address 0 of the csr port and resets to 4.
module line_code_4b5b_frame_receiver_unit
   import lc4b5b_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // bit input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_line_bit,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_received_byte,
   output logic        rsp_last_of_frame,
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]   payload_length_ff;
   logic [8:0]   shift_ff, shift_in;
   logic [3:0]   pos_ff, pos_in;
   phase_type    phase_ff, phase_in;
   logic [7:0]   count_ff, count_in;
   logic [7:0]   csum_ff, csum_in;

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff, skid_item_in;

   logic         req_accept;
   logic         rsp_pop;
   logic         produce;
   rsp_item_type new_item;
   logic [9:0]   pair;
   logic [7:0]   dec_byte;
   logic [7:0]   eff_len;
   logic [7:0]   count_next;
   logic         csr_write;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = out_valid_ff && rsp_ready;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_PAYLOAD_LENGTH);
   assign csr_prdata = (csr_paddr[2] == REG_PAYLOAD_LENGTH) ? {24'd0, payload_length_ff}
                                                            : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_length_ff <= 8'd4;
      end else if (csr_write) begin
         payload_length_ff <= csr_pwdata[7:0];
      end
   end

   // symbol pair decode, new bit lands on top
   assign pair     = {req_line_bit, shift_ff};
   assign dec_byte = {decode_symbol(pair[9:5]), decode_symbol(pair[4:0])};
   assign eff_len  = (payload_length_ff > MAX_LEN_CAP) ? MAX_LEN_CAP : payload_length_ff;
   assign count_next = count_ff + 8'd1;

   // next state of shifter and frame machine
   always_comb begin
      shift_in = shift_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      csum_in  = csum_ff;
      produce  = 1'b0;
      new_item = '{result_kind: KIND_PAYLOAD, received_byte: dec_byte, last_of_frame: 1'b0};
      if (req_accept) begin
         if (pos_ff >= LAST_BIT_POS) begin
            pos_in = 4'd0;
            unique case (phase_ff)
               PH_HUNT1: begin
                  if (dec_byte == START_A) begin
                     phase_in = PH_HUNT2;
                  end
               end
               PH_HUNT2: begin
                  if (dec_byte == START_B) begin
                     csum_in  = CHECK_SEED;
                     count_in = 8'd0;
                     phase_in = (eff_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                  end else begin
                     phase_in = PH_HUNT1;
                  end
               end
               PH_PAYLOAD: begin
                  csum_in  = csum_ff ^ dec_byte;
                  count_in = count_next;
                  if (count_next >= eff_len) begin
                     phase_in = PH_CHECK;
                  end
                  produce  = 1'b1;
               end
               PH_CHECK: begin
                  new_item.result_kind   = (dec_byte == csum_ff) ? KIND_GOOD : KIND_BAD;
                  new_item.last_of_frame = 1'b1;
                  produce  = 1'b1;
                  phase_in = PH_HUNT1;
                  count_in = 8'd0;
                  csum_in  = CHECK_SEED;
               end
               default: phase_in = PH_HUNT1;
            endcase
         end else begin
            shift_in = {req_line_bit, shift_ff[8:1]};
            pos_in   = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         phase_ff <= PH_HUNT1;
         count_ff <= 8'd0;
         csum_ff  <= CHECK_SEED;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         csum_ff  <= csum_in;
      end
   end

   // shifter holds payload only, position qualifies it
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // two-entry result buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || rsp_pop) begin
            out_valid_in = 1'b1;
            out_item_in  = new_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = new_item;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_item_ff.result_kind;
   assign rsp_received_byte = out_item_ff.received_byte;
   assign rsp_last_of_frame = out_item_ff.last_of_frame;

endmodule

/* hdl/lc4b5b_checker.sv */
// ----------------------------------------------------------------------------
// lc4b5b_checker
// Port-level checks for the 4B5B frame receiver, bound to its top level.
// ----------------------------------------------------------------------------
module lc4b5b_checker
   import lc4b5b_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_received_byte,
   input logic       rsp_last_of_frame
);

   // status results and only they close a frame
   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_frame == (rsp_result_kind != KIND_PAYLOAD)))
      else $error("last_of_frame disagrees with result_kind");

   // only defined result kinds appear
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == KIND_PAYLOAD || rsp_result_kind == KIND_GOOD
                     || rsp_result_kind == KIND_BAD))
      else $error("undefined result_kind");

   // input stalls only when results are backed up
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no pending result");

   // nothing left over after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result buffer not empty after reset");

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_kind)
                                     && $stable(rsp_received_byte)
                                     && $stable(rsp_last_of_frame)))
      else $error("stalled result transfer changed");

endmodule

bind line_code_4b5b_frame_receiver_unit lc4b5b_checker u_lc4b5b_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_received_byte (rsp_received_byte),
   .rsp_last_of_frame (rsp_last_of_frame)
);

/* test/line_code_4b5b_frame_receiver_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_code_4b5b_frame_receiver_unit_tb
// Drives 4B5B-coded line bits into the frame receiver and checks each result.
// Directed frames cover start-byte hunting, zero and largest length settings,
// length changes in mid-frame, every 5-bit code and bad checksums. A random
// part mixes well-formed frames with noise and broken start sequences. A
// bit-level model of the receiver predicts every payload byte and frame
// status, and the checker compares them in order with the results.
// ----------------------------------------------------------------------------
module line_code_4b5b_frame_receiver_unit_tb;
   import lc4b5b_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam logic [2:0]  LENGTH_ADDR = 3'(4 * int'(REG_PAYLOAD_LENGTH));

   // 4B5B code to nibble, unknown codes give 0
   localparam logic [3:0] NIBBLE_OF [32] = '{
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h1, 4'h4, 4'h5, 4'h0, 4'h0, 4'h6, 4'h7,
      4'h0, 4'h0, 4'h8, 4'h9, 4'h2, 4'h3, 4'hA, 4'hB,
      4'h0, 4'h0, 4'hC, 4'hD, 4'hE, 4'hF, 4'h0, 4'h0
   };

   // nibble to 4B5B code
   localparam logic [4:0] CODE_OF [16] = '{
      5'b11110, 5'b01001, 5'b10100, 5'b10101, 5'b01010, 5'b01011, 5'b01110, 5'b01111,
      5'b10010, 5'b10011, 5'b10110, 5'b10111, 5'b11010, 5'b11011, 5'b11100, 5'b11101
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_line_bit;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_received_byte;
   logic        rsp_last_of_frame;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // receiver model state
   logic [9:0]  sym_shift;
   logic [3:0]  bit_pos;
   phase_type   rx_phase;
   logic [7:0]  byte_count;
   logic [7:0]  xor_sum;
   logic [7:0]  length_reg;

   rsp_item_type rx_results_due[$];
   rsp_item_type due_item;
   rsp_item_type got_item;

   logic [7:0]  tx_sum;
   logic        req_gap_on;
   logic        rsp_stall_on;
   int unsigned bits_sent;
   int unsigned failures;
   int unsigned cycle_count;

   line_code_4b5b_frame_receiver_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_line_bit      (req_line_bit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_received_byte (rsp_received_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t run limit reached with %0d results due", $time, rx_results_due.size());
         $display("status: fail");
         $finish;
      end
   end

   // model one accepted line bit; a completed symbol pair may queue a result
   function automatic void advance_receiver(input logic line_bit);
      logic [7:0] rx_byte;
      logic [7:0] eff_len;
      eff_len = (length_reg > MAX_LEN_CAP) ? MAX_LEN_CAP : length_reg;
      if (bit_pos < 4'd10) sym_shift = sym_shift | (10'(line_bit) << bit_pos);
      bit_pos = bit_pos + 4'd1;
      if (bit_pos < 4'd10) return;
      rx_byte = {NIBBLE_OF[sym_shift[9:5]], NIBBLE_OF[sym_shift[4:0]]};
      sym_shift = '0;
      bit_pos = '0;
      case (rx_phase)
         PH_HUNT1: begin
            if (rx_byte == START_A) rx_phase = PH_HUNT2;
         end
         PH_HUNT2: begin
            if (rx_byte == START_B) begin
               xor_sum = CHECK_SEED;
               byte_count = '0;
               rx_phase = (eff_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end else begin
               rx_phase = PH_HUNT1;
            end
         end
         PH_PAYLOAD: begin
            xor_sum = xor_sum ^ rx_byte;
            byte_count = byte_count + 8'd1;
            if (byte_count >= eff_len) rx_phase = PH_CHECK;
            rx_results_due.push_back('{KIND_PAYLOAD, rx_byte, 1'b0});
         end
         default: begin
            rx_results_due.push_back('{(rx_byte == xor_sum) ? KIND_GOOD : KIND_BAD,
                                       rx_byte, 1'b1});
            rx_phase = PH_HUNT1;
            byte_count = '0;
            xor_sum = CHECK_SEED;
         end
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_item = '{rsp_result_kind, rsp_received_byte, rsp_last_of_frame};
         if (rx_results_due.size() == 0) begin
            $display("%0t unexpected result: expected none, actual kind %0d byte %02h last %0b",
                     $time, got_item.result_kind, got_item.received_byte,
                     got_item.last_of_frame);
            failures++;
         end else begin
            due_item = rx_results_due.pop_front();
            if (got_item !== due_item) begin
               $display("%0t result mismatch: expected kind %0d byte %02h last %0b, %s",
                        $time, due_item.result_kind, due_item.received_byte,
                        due_item.last_of_frame,
                        $sformatf("actual kind %0d byte %02h last %0b",
                                  got_item.result_kind, got_item.received_byte,
                                  got_item.last_of_frame));
               failures++;
            end
         end
      end
   end

   // result side stalls in random bursts
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // one line bit transfer, with an optional gap before it
   task automatic send_bit(input logic line_bit);
      if (req_gap_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_bit <= line_bit;
      do @(posedge clock); while (!req_ready);
      bits_sent++;
      advance_receiver(line_bit);
   endtask

   // ten bits, lsb first
   task automatic send_word(input logic [9:0] word);
      for (int i = 0; i < 10; i++) send_bit(word[i]);
   endtask

   task automatic send_coded_byte(input logic [7:0] data);
      send_word({CODE_OF[data[7:4]], CODE_OF[data[3:0]]});
   endtask

   task automatic send_start();
      tx_sum = CHECK_SEED;
      send_coded_byte(START_A);
      send_coded_byte(START_B);
   endtask

   // payload symbol pair, raw so that unknown codes can be sent too
   task automatic send_payload_word(input logic [9:0] word);
      tx_sum = tx_sum ^ {NIBBLE_OF[word[9:5]], NIBBLE_OF[word[4:0]]};
      send_word(word);
   endtask

   task automatic send_payload(input logic [7:0] data);
      send_payload_word({CODE_OF[data[7:4]], CODE_OF[data[3:0]]});
   endtask

   task automatic send_checksum(input logic corrupt);
      send_coded_byte(corrupt ? tx_sum ^ 8'($urandom_range(1, 255)) : tx_sum);
   endtask

   // whole frame at the current length, random content
   task automatic send_frame(input logic corrupt);
      send_start();
      for (int i = 0; i < int'(length_reg); i++) begin
         if ($urandom_range(0, 7) == 0) send_payload_word(10'($urandom_range(0, 1023)));
         else send_payload(8'($urandom_range(0, 255)));
      end
      send_checksum(corrupt);
   endtask

   // bring the symbol boundary back to the start of a pair
   task automatic realign();
      while (bit_pos != 4'd0) send_bit(1'($urandom_range(0, 1)));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (rx_results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic check_length_reg(input logic [7:0] want);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= LENGTH_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== want) begin
         $display("%0t payload_length read: expected %0d, actual %0d",
                  $time, want, csr_prdata[7:0]);
         failures++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // register writes only once all results are in
   task automatic write_length(input logic [7:0] len);
      drain_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= LENGTH_ADDR;
      csr_pwdata <= 32'(len);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      length_reg = len;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      check_length_reg(len);
   endtask

   // reset length and a frame with extreme payload bytes
   task automatic test_reset_length();
      check_length_reg(8'd4);
      send_start();
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h5A);
      send_payload(8'hA5);
      send_checksum(1'b0);
   endtask

   // non-start bytes are dropped; a wrong second byte restarts the hunt
   task automatic test_start_hunt();
      send_coded_byte(8'h55);
      send_coded_byte(START_A);
      send_coded_byte(START_A);
      send_coded_byte(START_B);
      send_coded_byte(START_B);
      send_frame(1'b0);
   endtask

   task automatic test_bad_checksum();
      send_frame(1'b1);
      send_frame(1'b0);
   endtask

   // all 32 codes as payload, unknown ones decode to zero
   task automatic test_all_codes();
      write_length(8'd16);
      send_start();
      for (int k = 0; k < 16; k++) send_payload_word({5'(2 * k + 1), 5'(2 * k)});
      send_checksum(1'b0);
   endtask

   // with no payload the byte after the start pair is the checksum
   task automatic test_zero_length();
      write_length(8'd0);
      send_frame(1'b0);
      send_frame(1'b1);
   endtask

   // shorter length in mid-frame ends the payload at the next byte
   task automatic test_length_change();
      write_length(8'd6);
      send_start();
      for (int i = 0; i < 3; i++) send_payload(8'($urandom_range(0, 255)));
      write_length(8'd1);
      send_payload(8'($urandom_range(0, 255)));
      send_checksum(1'b0);
   endtask

   // largest length setting, frame closed early by a shorter length
   task automatic test_max_length();
      write_length(8'd255);
      send_start();
      for (int i = 0; i < 5; i++) send_payload(8'($urandom_range(0, 255)));
      write_length(8'd2);
      send_payload(8'($urandom_range(0, 255)));
      send_checksum(1'b0);
      write_length(8'd1);
      send_frame(1'b0);
   endtask

   // mostly frames, with noise, misalignment and broken start sequences
   task automatic test_random();
      int unsigned first_bit;
      int unsigned pick;
      first_bit = bits_sent;
      while (bits_sent - first_bit < 250) begin
         req_gap_on = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 11);
         if (pick == 0) begin
            write_length(8'($urandom_range(0, 6)));
         end else if (pick == 1) begin
            repeat ($urandom_range(1, 25)) send_bit(1'($urandom_range(0, 1)));
            realign();
         end else if (pick == 2) begin
            send_coded_byte(START_A);
            send_coded_byte(8'($urandom_range(0, 255)));
         end else begin
            send_frame($urandom_range(0, 3) == 0);
         end
      end
   endtask

   // closing stretch at full rate
   task automatic test_steady();
      write_length(8'd4);
      repeat (4) send_frame($urandom_range(0, 3) == 0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_line_bit = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sym_shift = '0;
      bit_pos = '0;
      rx_phase = PH_HUNT1;
      byte_count = '0;
      xor_sum = CHECK_SEED;
      length_reg = 8'd4;
      tx_sum = CHECK_SEED;
      req_gap_on = 1'b1;
      rsp_stall_on = 1'b1;
      bits_sent = 0;
      failures = 0;
      cycle_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length();
      test_start_hunt();
      test_bad_checksum();
      test_all_codes();
      test_zero_length();
      test_length_change();
      test_max_length();
      test_random();
      req_gap_on = 1'b0;
      rsp_stall_on = 1'b0;
      test_steady();
      drain_results();

      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
hdl/lc4b5b_pkg.sv
hdl/line_code_4b5b_frame_receiver_unit.sv
hdl/lc4b5b_checker.sv
test/line_code_4b5b_frame_receiver_unit_tb.sv
